// File: hw/rtl/gas_pkg.sv
// Shared types, constants and helpers of the grid A* search core.
package gas_pkg;

	// Grid and storage geometry
	localparam int GridW    = 64;
	localparam int GridH    = 64;
	localparam int Cells    = GridW * GridH;
	localparam int MaxPath  = 4096;
	localparam int HeapCap  = 4 * Cells + 1;
	localparam int HeapAw   = $clog2(HeapCap);
	localparam int CellW    = $clog2(Cells);

	localparam logic [12:0] COST_MAX = 13'h1FFF;
	localparam logic [12:0] PAR_NONE = 13'h1000;

	// Request commands
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_OOB      = 3'd2;
	localparam logic [2:0] ST_BLOCKED  = 3'd3;
	localparam logic [2:0] ST_EMPTY    = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MAXLEN = 2'd2;

	// Controller states, also the command code to the datapath
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RDW    = 5'd1;
	localparam logic [4:0] S_CHK    = 5'd2;
	localparam logic [4:0] S_CLR    = 5'd3;
	localparam logic [4:0] S_INIT   = 5'd4;
	localparam logic [4:0] S_POP    = 5'd5;
	localparam logic [4:0] S_POP2   = 5'd6;
	localparam logic [4:0] S_SDRD   = 5'd7;
	localparam logic [4:0] S_SDCMP  = 5'd8;
	localparam logic [4:0] S_CURRD  = 5'd9;
	localparam logic [4:0] S_CURCHK = 5'd10;
	localparam logic [4:0] S_NBRD   = 5'd11;
	localparam logic [4:0] S_NBCHK  = 5'd12;
	localparam logic [4:0] S_SURD   = 5'd13;
	localparam logic [4:0] S_SUCMP  = 5'd14;
	localparam logic [4:0] S_PCRD   = 5'd15;
	localparam logic [4:0] S_PCW    = 5'd16;
	localparam logic [4:0] S_PWI    = 5'd17;
	localparam logic [4:0] S_PWRD   = 5'd18;
	localparam logic [4:0] S_PWW    = 5'd19;
	localparam logic [4:0] S_RESP   = 5'd20;
	// Grid clearing pass after reset
	localparam logic [4:0] S_BOOT   = 5'd21;

	// One open-set entry
	typedef struct packed {
		logic [11:0] loc;
		logic [12:0] g;
		logic [12:0] f;
	} hnode_t;

	// Datapath status toward the controller
	typedef struct packed {
		logic [1:0] req_cmd;
		logic       pre_fail;
		logic       rd_oob;
		logic       ends_blocked;
		logic       clr_last;
		logic       heap_empty;
		logic       sd_done;
		logic       cur_closed;
		logic       cur_goal;
		logic       nb_valid;
		logic       nb_push;
		logic       dir_last;
		logic       su_root;
		logic       su_stop;
		logic       c_none;
		logic       pw_done;
	} dp_stat_t;

	// Absolute difference of two coordinates
	function automatic logic [5:0] dist6(input logic [5:0] a, input logic [5:0] b);
		dist6 = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// File: hw/rtl/gas_if.sv
// Channel interfaces of the grid A* search core.
interface gas_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [5:0]  cell_x;
	logic [5:0]  cell_y;
	logic        cell_blocked;
	logic [5:0]  start_x;
	logic [5:0]  start_y;
	logic [5:0]  goal_x;
	logic [5:0]  goal_y;
	logic [11:0] path_index;
	modport source(output valid, cmd, cell_x, cell_y, cell_blocked, start_x, start_y,
		goal_x, goal_y, path_index, input ready);
	modport sink(input valid, cmd, cell_x, cell_y, cell_blocked, start_x, start_y,
		goal_x, goal_y, path_index, output ready);
endinterface

interface gas_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [12:0] path_length;
	logic [5:0]  path_x;
	logic [5:0]  path_y;
	modport source(output valid, status, path_length, path_x, path_y, input ready);
	modport sink(input valid, status, path_length, path_x, path_y, output ready);
endinterface

interface gas_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/grid_astar_path_search_core.sv
// Top level of the grid A* path search core.
//
//   channel  role   carries
//   req      sink   cmd, cell, start/goal, path_index
//   rsp      source status, path_length, path_x, path_y
//   cfg      sink   register index and write data (always ready)
//
// After reset the core clears the whole grid before it takes a request.
// A cell write, an unused command or a read past the end goes straight to the response,
// and a path read reads the path memory first. A search first clears the per-cell memories,
// then for each heap pop walks the sift-down levels, and for each neighbor the sift-up
// levels; the single heap write port paces these steps. Path output takes two parent walks
// (count, then write). One request is in flight; a held response stalls the input.
module grid_astar_path_search_core import gas_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	gas_req_if.sink   req,
	gas_rsp_if.source rsp,
	gas_cfg_if.sink   cfg
);

	dp_stat_t   stat;
	logic [4:0] op;

	assign cfg.ready = 1'b1;

	gas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.op        (op),
		.in_ready  (req.ready),
		.out_valid (rsp.valid)
	);

	gas_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.in_valid     (req.valid),
		.cmd          (req.cmd),
		.cell_x       (req.cell_x),
		.cell_y       (req.cell_y),
		.cell_blocked (req.cell_blocked),
		.start_x      (req.start_x),
		.start_y      (req.start_y),
		.goal_x       (req.goal_x),
		.goal_y       (req.goal_y),
		.path_index   (req.path_index),
		.cfg_valid    (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.stat         (stat),
		.res_status   (rsp.status),
		.res_length   (rsp.path_length),
		.res_x        (rsp.path_x),
		.res_y        (rsp.path_y)
	);

	// A pending response blocks new requests.
	a_rsp_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("request taken while response pending");

	// An accepted request makes the core busy on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready) else $error("core not busy after request");

	// Status codes stay within the defined set.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status <= ST_EMPTY)) else $error("bad status code");

endmodule

// File: hw/rtl/gas_ctrl.sv
// Sequencing state machine of the grid A* search core.
module gas_ctrl import gas_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_ready,
	input  dp_stat_t   stat,
	output logic [4:0] op,
	output logic       in_ready,
	output logic       out_valid
);

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign op        = state_q;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESP);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_BOOT:   state_d = stat.clr_last ? S_IDLE : S_BOOT;
			S_IDLE: begin
				if (in_valid) begin
					unique case (stat.req_cmd)
						CMD_SEARCH: state_d = stat.pre_fail ? S_RESP : S_CHK;
						CMD_READ:   state_d = stat.rd_oob ? S_RESP : S_RDW;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_RDW:    state_d = S_RESP;
			S_CHK:    state_d = stat.ends_blocked ? S_RESP : S_CLR;
			S_CLR:    state_d = stat.clr_last ? S_INIT : S_CLR;
			S_INIT:   state_d = S_POP;
			S_POP:    state_d = stat.heap_empty ? S_RESP : S_POP2;
			S_POP2:   state_d = S_SDRD;
			S_SDRD:   state_d = S_SDCMP;
			S_SDCMP:  state_d = stat.sd_done ? S_CURRD : S_SDRD;
			S_CURRD:  state_d = S_CURCHK;
			S_CURCHK: begin
				priority if (stat.cur_closed) state_d = S_POP;
				else if (stat.cur_goal) state_d = S_PCRD;
				else state_d = S_NBRD;
			end
			S_NBRD: begin
				priority if (stat.nb_valid) state_d = S_NBCHK;
				else if (stat.dir_last) state_d = S_POP;
				else state_d = S_NBRD;
			end
			S_NBCHK: begin
				priority if (stat.nb_push) state_d = S_SURD;
				else if (stat.dir_last) state_d = S_POP;
				else state_d = S_NBRD;
			end
			S_SURD: begin
				if (stat.su_root) begin
					state_d = stat.dir_last ? S_POP : S_NBRD;
				end else begin
					state_d = S_SUCMP;
				end
			end
			S_SUCMP: begin
				if (stat.su_stop) begin
					state_d = stat.dir_last ? S_POP : S_NBRD;
				end else begin
					state_d = S_SURD;
				end
			end
			S_PCRD:   state_d = stat.c_none ? S_PWI : S_PCW;
			S_PCW:    state_d = S_PCRD;
			S_PWI:    state_d = S_PWRD;
			S_PWRD:   state_d = stat.pw_done ? S_RESP : S_PWW;
			S_PWW:    state_d = S_PWRD;
			S_RESP:   state_d = out_ready ? S_IDLE : S_RESP;
			default:  state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/gas_dpath.sv
// Memories, registers and arithmetic of the grid A* search core.
module gas_dpath import gas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  op,
	input  logic        in_valid,
	input  logic [1:0]  cmd,
	input  logic [5:0]  cell_x,
	input  logic [5:0]  cell_y,
	input  logic        cell_blocked,
	input  logic [5:0]  start_x,
	input  logic [5:0]  start_y,
	input  logic [5:0]  goal_x,
	input  logic [5:0]  goal_y,
	input  logic [11:0] path_index,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output dp_stat_t    stat,
	output logic [2:0]  res_status,
	output logic [12:0] res_length,
	output logic [5:0]  res_x,
	output logic [5:0]  res_y
);

	// Configuration registers and their clamped values
	logic [6:0]  w_q, h_q, w_eff, h_eff;
	logic [12:0] lim_q, lim_eff;

	assign w_eff   = (w_q > 7'(GridW)) ? 7'(GridW) : w_q;
	assign h_eff   = (h_q > 7'(GridH)) ? 7'(GridH) : h_q;
	assign lim_eff = (lim_q > 13'(MaxPath)) ? 13'(MaxPath) : lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= 7'(GridW);
			h_q   <= 7'(GridH);
			lim_q <= 13'(MaxPath);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  w_q   <= cfg_data[6:0];
				REG_HEIGHT: h_q   <= cfg_data[6:0];
				REG_MAXLEN: lim_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	logic fire;
	assign fire = (op == S_IDLE) && in_valid;

	// Search registers
	logic [5:0]        sx_q, sy_q, gx_q, gy_q;
	logic [11:0]       clr_q;
	hnode_t            cur_q, mov_q;
	logic [HeapAw-1:0] i_q, cnt_q;
	logic [1:0]        dir_q;
	logic [11:0]       nidx_q;
	logic              l_in_q, r_in_q;
	logic [12:0]       c_q, pcnt_q, plen_q, k_q, stored_len_q;
	logic [2:0]        status_q;
	logic [5:0]        px_q, py_q;

	logic [11:0] sidx, gidx;
	assign sidx = {sy_q, sx_q};
	assign gidx = {gy_q, gx_q};

	// Early checks on an incoming request
	logic [2:0] fire_status;
	logic       pre_fail, rd_oob;
	always_comb begin
		fire_status = ST_OK;
		rd_oob      = ({1'b0, path_index} >= stored_len_q);
		pre_fail    = 1'b0;
		if (cmd == CMD_SEARCH) begin
			priority if (w_eff == 7'd0 || h_eff == 7'd0) begin
				pre_fail    = 1'b1;
				fire_status = ST_EMPTY;
			end else if ({1'b0, start_x} >= w_eff || {1'b0, start_y} >= h_eff ||
				{1'b0, goal_x} >= w_eff || {1'b0, goal_y} >= h_eff) begin
				pre_fail    = 1'b1;
				fire_status = ST_OOB;
			end else begin
				pre_fail    = 1'b0;
			end
		end else if (cmd == CMD_READ && rd_oob) begin
			fire_status = ST_OOB;
		end
	end

	// Neighbor of the current cell in the current direction
	logic [5:0]  cx, cy, nx, ny;
	logic        nb_valid;
	logic [11:0] nidx;
	assign cx = cur_q.loc[5:0];
	assign cy = cur_q.loc[11:6];
	always_comb begin
		nx = cx;
		ny = cy;
		unique case (dir_q)
			2'd0: begin
				nx       = cx + 6'd1;
				nb_valid = ({1'b0, cx} + 7'd1) < w_eff;
			end
			2'd1: begin
				nx       = cx - 6'd1;
				nb_valid = (cx != 6'd0);
			end
			2'd2: begin
				ny       = cy + 6'd1;
				nb_valid = ({1'b0, cy} + 7'd1) < h_eff;
			end
			default: begin
				ny       = cy - 6'd1;
				nb_valid = (cy != 6'd0);
			end
		endcase
	end
	assign nidx = {ny, nx};

	// Grid occupancy memory, cleared entry by entry in the boot pass after reset
	logic        grid_mem [Cells];
	logic        grd_a_q, grd_b_q;
	logic [11:0] grid_ra;
	assign grid_ra = (op == S_NBRD) ? nidx : {start_y, start_x};
	always_ff @(posedge clk) begin
		if (op == S_BOOT) begin
			grid_mem[clr_q] <= 1'b0;
		end else if (fire && cmd == CMD_WRITE) begin
			grid_mem[{cell_y, cell_x}] <= cell_blocked;
		end
		grd_a_q <= grid_mem[grid_ra];
		grd_b_q <= grid_mem[{goal_y, goal_x}];
	end

	// Per-cell search memories: closed flag, best cost, parent
	logic        closed_mem [Cells];
	logic [12:0] cost_mem [Cells];
	logic [12:0] par_mem [Cells];
	logic        closed_rd_q;
	logic [12:0] cost_rd_q, par_rd_q;
	logic [11:0] nw_addr, nr_addr;
	logic        closed_we, cost_we, par_we, closed_wd;
	logic [12:0] cost_wd, par_wd;

	// Relaxation arithmetic
	logic [12:0] tg, nf;
	logic        nb_ok, push_ok;
	assign tg      = cur_q.g + 13'd1;
	assign nf      = tg + {7'd0, dist6(nidx_q[5:0], gx_q)} + {7'd0, dist6(nidx_q[11:6], gy_q)};
	assign nb_ok   = !grd_a_q && !closed_rd_q && (tg < cost_rd_q);
	assign push_ok = (cnt_q < HeapAw'(HeapCap));

	always_comb begin
		closed_we = 1'b0;
		cost_we   = 1'b0;
		par_we    = 1'b0;
		closed_wd = 1'b0;
		cost_wd   = COST_MAX;
		par_wd    = PAR_NONE;
		nw_addr   = clr_q;
		unique case (op)
			S_CLR: begin
				closed_we = 1'b1;
				cost_we   = 1'b1;
				par_we    = 1'b1;
			end
			S_INIT: begin
				cost_we = 1'b1;
				cost_wd = 13'd0;
				nw_addr = sidx;
			end
			S_CURCHK: begin
				closed_we = !closed_rd_q;
				closed_wd = 1'b1;
				nw_addr   = cur_q.loc;
			end
			S_NBCHK: begin
				cost_we = nb_ok;
				par_we  = nb_ok;
				cost_wd = tg;
				par_wd  = {1'b0, cur_q.loc};
				nw_addr = nidx_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (op)
			S_CURRD:        nr_addr = cur_q.loc;
			S_NBRD:         nr_addr = nidx;
			S_PCRD, S_PWRD: nr_addr = c_q[11:0];
			default:        nr_addr = 12'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (closed_we) closed_mem[nw_addr] <= closed_wd;
		if (cost_we) cost_mem[nw_addr] <= cost_wd;
		if (par_we) par_mem[nw_addr] <= par_wd;
		closed_rd_q <= closed_mem[nr_addr];
		cost_rd_q   <= cost_mem[nr_addr];
		par_rd_q    <= par_mem[nr_addr];
	end

	// Open-set heap memory with two read ports
	hnode_t            heap_mem [HeapCap];
	hnode_t            hrd_a_q, hrd_b_q, hw_data, sd_child;
	logic [HeapAw-1:0] ha, hb, hw_addr, hp, sd_next;
	logic              hw_en, lsel, rsel, sd_done, su_stop;
	logic [HeapAw:0]   hl, hr;
	logic [12:0]       mf;

	assign hl = {i_q, 1'b1};
	assign hr = hl + (HeapAw+1)'(1);
	assign hp = (i_q - HeapAw'(1)) >> 1;

	// Sift-down child choice
	always_comb begin
		lsel     = l_in_q && (hrd_a_q.f < mov_q.f);
		mf       = lsel ? hrd_a_q.f : mov_q.f;
		rsel     = r_in_q && (hrd_b_q.f < mf);
		sd_done  = !lsel && !rsel;
		sd_child = rsel ? hrd_b_q : hrd_a_q;
		sd_next  = rsel ? hr[HeapAw-1:0] : hl[HeapAw-1:0];
	end
	assign su_stop = (hrd_a_q.f <= mov_q.f);

	always_comb begin
		ha = '0;
		hb = '0;
		unique case (op)
			S_POP: hb = (cnt_q == '0) ? '0 : (cnt_q - HeapAw'(1));
			S_SDRD: begin
				ha = (hl < {1'b0, cnt_q}) ? hl[HeapAw-1:0] : '0;
				hb = (hr < {1'b0, cnt_q}) ? hr[HeapAw-1:0] : '0;
			end
			S_SURD:  ha = hp;
			default: ;
		endcase
	end

	always_comb begin
		hw_en   = 1'b0;
		hw_addr = i_q;
		hw_data = mov_q;
		unique case (op)
			S_INIT: begin
				hw_en   = 1'b1;
				hw_addr = '0;
				hw_data = '{loc: sidx, g: 13'd0,
					f: {7'd0, dist6(sx_q, gx_q)} + {7'd0, dist6(sy_q, gy_q)}};
			end
			S_SDCMP: begin
				hw_en   = 1'b1;
				hw_data = sd_done ? mov_q : sd_child;
			end
			S_SURD: begin
				hw_en   = (i_q == '0);
				hw_addr = '0;
			end
			S_SUCMP: begin
				hw_en   = 1'b1;
				hw_data = su_stop ? mov_q : hrd_a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hw_en) heap_mem[hw_addr] <= hw_data;
		hrd_a_q <= heap_mem[ha];
		hrd_b_q <= heap_mem[hb];
	end

	// Path memory, written in the second parent walk
	logic [11:0] path_mem [MaxPath];
	logic [11:0] prd_q;
	logic [12:0] pw_addr;
	logic        pw_done, dir_adv;
	assign pw_done = (k_q == plen_q);
	assign pw_addr = plen_q - 13'd1 - k_q;
	always_ff @(posedge clk) begin
		if (op == S_PWRD && !pw_done) path_mem[pw_addr[11:0]] <= c_q[11:0];
		prd_q <= path_mem[path_index];
	end

	assign dir_adv = (op == S_NBRD && !nb_valid) || (op == S_NBCHK && !(nb_ok && push_ok)) ||
		(op == S_SURD && i_q == '0) || (op == S_SUCMP && su_stop);

	// Control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			stored_len_q <= 13'd0;
			dir_q        <= 2'd0;
			clr_q        <= 12'd0;
		end else begin
			if (op == S_INIT) cnt_q <= HeapAw'(1);
			if (op == S_POP && cnt_q != '0) cnt_q <= cnt_q - HeapAw'(1);
			if (op == S_NBCHK && nb_ok && push_ok) cnt_q <= cnt_q + HeapAw'(1);
			if (op == S_PWRD && pw_done) stored_len_q <= plen_q;
			if (op == S_CURCHK) dir_q <= 2'd0;
			else if (dir_adv) dir_q <= dir_q + 2'd1;
			if (op == S_CHK) clr_q <= 12'd0;
			else if (op == S_CLR || op == S_BOOT) clr_q <= clr_q + 12'd1;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (fire) begin
			sx_q     <= start_x;
			sy_q     <= start_y;
			gx_q     <= goal_x;
			gy_q     <= goal_y;
			status_q <= fire_status;
			px_q     <= 6'd0;
			py_q     <= 6'd0;
		end
		unique case (op)
			S_RDW: begin
				px_q <= prd_q[5:0];
				py_q <= prd_q[11:6];
			end
			S_CHK: if (grd_a_q || grd_b_q) status_q <= ST_BLOCKED;
			S_POP: if (cnt_q == '0) status_q <= ST_NOTFOUND;
			S_POP2: begin
				cur_q <= hrd_a_q;
				mov_q <= hrd_b_q;
				i_q   <= '0;
			end
			S_SDRD: begin
				l_in_q <= (hl < {1'b0, cnt_q});
				r_in_q <= (hr < {1'b0, cnt_q});
			end
			S_SDCMP: if (!sd_done) i_q <= sd_next;
			S_CURCHK: begin
				c_q    <= {1'b0, gidx};
				pcnt_q <= 13'd0;
			end
			S_NBRD: nidx_q <= nidx;
			S_NBCHK: begin
				if (nb_ok && push_ok) begin
					mov_q <= '{loc: nidx_q, g: tg, f: nf};
					i_q   <= cnt_q;
				end
			end
			S_SUCMP: if (!su_stop) i_q <= hp;
			S_PCRD: if (!c_q[12]) pcnt_q <= pcnt_q + 13'd1;
			S_PCW, S_PWW: c_q <= par_rd_q;
			S_PWI: begin
				plen_q <= (pcnt_q < lim_eff) ? pcnt_q : lim_eff;
				k_q    <= 13'd0;
				c_q    <= {1'b0, gidx};
			end
			S_PWRD: if (!pw_done) k_q <= k_q + 13'd1;
			default: ;
		endcase
	end

	// Status toward the controller
	always_comb begin
		stat.req_cmd      = cmd;
		stat.pre_fail     = pre_fail;
		stat.rd_oob       = rd_oob;
		stat.ends_blocked = grd_a_q || grd_b_q;
		stat.clr_last     = (clr_q == 12'hFFF);
		stat.heap_empty   = (cnt_q == '0);
		stat.sd_done      = sd_done;
		stat.cur_closed   = closed_rd_q;
		stat.cur_goal     = (cur_q.loc == gidx);
		stat.nb_valid     = nb_valid;
		stat.nb_push      = nb_ok && push_ok;
		stat.dir_last     = (dir_q == 2'd3);
		stat.su_root      = (i_q == '0);
		stat.su_stop      = su_stop;
		stat.c_none       = c_q[12];
		stat.pw_done      = pw_done;
	end

	assign res_status = status_q;
	assign res_length = stored_len_q;
	assign res_x      = px_q;
	assign res_y      = py_q;

endmodule
